### src/cvfs_pkg.sv
package cvfs_pkg;

    localparam int CHANNELS_PER_CHIP = 12;
    localparam int MAX_CELLS         = 60;
    localparam int MASK_W            = 60;
    localparam int VOLT_W            = 16;
    localparam int IDX_W             = 6;
    localparam int TOTAL_W           = 22;

    localparam logic [VOLT_W-1:0] INVALID_READING = 16'hffff;

    typedef struct packed {
        logic [VOLT_W-1:0] raw_voltage;
        logic              group_pec_error;
        logic              last_reading;
    } reading_t;

    typedef struct packed {
        logic [IDX_W-1:0]   cell_index;
        logic [VOLT_W-1:0]  cell_voltage;
        logic               summary_valid;
        logic [TOTAL_W-1:0] total_voltage;
        logic [VOLT_W-1:0]  max_voltage;
        logic [IDX_W-1:0]   max_index;
        logic [VOLT_W-1:0]  min_voltage;
        logic [IDX_W-1:0]   min_index;
        logic               frame_rejected;
        logic [IDX_W-1:0]   cell_count;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_SUMMARY
    } state_t;

    typedef struct packed {
        logic load;
        logic walk_clear;
        logic read_en;
        logic summary;
    } ctl_cmd_t;

endpackage

### src/cell_voltage_frame_stats.sv
// Readings of a frame are taken one per cycle while busy is low, chip-major and
// channel-minor. The reading that carries last_reading closes the frame: busy then
// stays high for one walk over the frame and good-value stores through their single
// read port, then for a state that drains the read stage and one that forms the
// summary. During the walk each masked channel gives a cell result on result_valid,
// and the summary follows in the first cycle after busy falls. Results are shown
// for one cycle only and cannot be held off, so the receiver must take every strobe.
// A frame with a PEC error still reports cells and summary from the previous good
// values, flagged rejected.
module cell_voltage_frame_stats
    import cvfs_pkg::*;
#(
    parameter int MONITOR_CHIPS = 5
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  reading_t          reading,
    input  logic              mask_we,
    input  logic [MASK_W-1:0] mask_wdata,
    output result_t           result,
    output logic              result_valid
);

    localparam int POSITIONS = MONITOR_CHIPS * CHANNELS_PER_CHIP;

    ctl_cmd_t cmd;
    logic     last_addr;

    cvfs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .last_reading (reading.last_reading),
        .last_addr    (last_addr),
        .busy         (busy),
        .cmd          (cmd)
    );

    cvfs_datapath #(
        .POSITIONS (POSITIONS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .reading      (reading),
        .mask_we      (mask_we),
        .mask_wdata   (mask_wdata),
        .last_addr    (last_addr),
        .result       (result),
        .result_valid (result_valid)
    );

`ifndef SYNTH
    a_close_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && reading.last_reading |=> busy)
        else $error("closing request did not start the walk");

    a_summary_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.summary_valid |-> !busy)
        else $error("summary shown while still busy");

    a_cell_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.summary_valid |-> busy
            && (result.cell_index < IDX_W'(MAX_CELLS)))
        else $error("cell result outside a walk or beyond the last cell");

    a_one_walk: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |=> !busy || $past(result_valid && result.summary_valid))
        else $error("walk finished without a summary");
`endif

endmodule

### src/cvfs_ctrl.sv
module cvfs_ctrl
    import cvfs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     last_reading,
    input  logic     last_addr,
    output logic     busy,
    output ctl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && last_reading)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (last_addr)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_SUMMARY;
            end
            ST_SUMMARY:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy           = 1'b1;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy           = 1'b0;
                cmd.load       = start;
                cmd.walk_clear = start && last_reading;
            end
            ST_WALK:
            begin
                cmd.read_en = 1'b1;
            end
            ST_DRAIN:
            begin
                cmd.read_en = 1'b0;
            end
            ST_SUMMARY:
            begin
                cmd.summary = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

### src/cvfs_datapath.sv
module cvfs_datapath
    import cvfs_pkg::*;
#(
    parameter int POSITIONS = 60
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctl_cmd_t          cmd,
    input  reading_t          reading,
    input  logic              mask_we,
    input  logic [MASK_W-1:0] mask_wdata,
    output logic              last_addr,
    output result_t           result,
    output logic              result_valid
);

    localparam int ADDR_W = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
    localparam int POS_W  = $clog2(POSITIONS + 1);

    logic [MASK_W-1:0] mask_reg;
    logic [POS_W-1:0]  pos_reg;
    logic              frame_err_reg;

    logic [VOLT_W-1:0] frame_mem [POSITIONS];
    logic [VOLT_W-1:0] good_mem  [POSITIONS];
    logic [POSITIONS-1:0] good_vld_reg;

    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] paddr_reg;
    logic              rd_vld_reg;
    logic [VOLT_W-1:0] fb_rd_reg;
    logic [VOLT_W-1:0] good_rd_reg;
    logic              good_vld_rd_reg;

    logic [IDX_W-1:0]   count_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [VOLT_W-1:0]  max_reg;
    logic [IDX_W-1:0]   max_idx_reg;
    logic [VOLT_W-1:0]  min_reg;
    logic [IDX_W-1:0]   min_idx_reg;

    result_t result_reg;
    result_t result_next;
    logic    strobe_reg;
    logic    strobe_next;

    logic              take;
    logic [VOLT_W-1:0] cur_good;
    logic [VOLT_W-1:0] cur_v;
    logic              emit;

    assign last_addr = (addr_reg == ADDR_W'(POSITIONS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '1;
        end
        else if (mask_we)
        begin
            mask_reg <= mask_wdata;
        end
    end

    // Position count and PEC error flag of the frame being loaded.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            frame_err_reg <= 1'b0;
        end
        else if (cmd.summary)
        begin
            pos_reg       <= '0;
            frame_err_reg <= 1'b0;
        end
        else if (cmd.load && (pos_reg < POS_W'(POSITIONS)))
        begin
            pos_reg <= pos_reg + 1'b1;
            if (reading.group_pec_error)
            begin
                frame_err_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && (pos_reg < POS_W'(POSITIONS)))
        begin
            frame_mem[pos_reg[ADDR_W-1:0]] <= reading.raw_voltage;
        end
        fb_rd_reg <= frame_mem[addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            good_mem[paddr_reg] <= cur_v;
        end
        good_rd_reg <= good_mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            good_vld_reg    <= '0;
            good_vld_rd_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                good_vld_reg[paddr_reg] <= 1'b1;
            end
            good_vld_rd_reg <= good_vld_reg[addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg   <= '0;
            paddr_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.walk_clear)
            begin
                addr_reg <= '0;
            end
            else if (cmd.read_en && !last_addr)
            begin
                addr_reg <= addr_reg + 1'b1;
            end
            paddr_reg  <= addr_reg;
            rd_vld_reg <= cmd.read_en;
        end
    end

    // A frame commits only where it was received, had no PEC error and the
    // reading is not the invalid code; the store is rewritten during the walk.
    always_comb
    begin
        cur_good = good_vld_rd_reg ? good_rd_reg : '0;
        take     = rd_vld_reg && !frame_err_reg
                   && (POS_W'(paddr_reg) < pos_reg)
                   && (fb_rd_reg != INVALID_READING);
        cur_v    = take ? fb_rd_reg : cur_good;
        emit     = rd_vld_reg && mask_reg[paddr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            total_reg   <= '0;
            max_reg     <= '0;
            max_idx_reg <= '0;
            min_reg     <= '0;
            min_idx_reg <= '0;
        end
        else if (cmd.walk_clear)
        begin
            count_reg   <= '0;
            total_reg   <= '0;
            max_reg     <= '0;
            max_idx_reg <= '0;
            min_reg     <= '0;
            min_idx_reg <= '0;
        end
        else if (emit)
        begin
            count_reg <= count_reg + 1'b1;
            total_reg <= total_reg + TOTAL_W'(cur_v);
            if (count_reg == '0)
            begin
                max_reg <= cur_v;
                min_reg <= cur_v;
            end
            else
            begin
                if (cur_v > max_reg)
                begin
                    max_reg     <= cur_v;
                    max_idx_reg <= count_reg;
                end
                if (cur_v < min_reg)
                begin
                    min_reg     <= cur_v;
                    min_idx_reg <= count_reg;
                end
            end
        end
    end

    always_comb
    begin
        result_next = '0;
        strobe_next = 1'b0;
        priority if (cmd.summary)
        begin
            strobe_next                = 1'b1;
            result_next.summary_valid  = 1'b1;
            result_next.total_voltage  = total_reg;
            result_next.max_voltage    = max_reg;
            result_next.max_index      = max_idx_reg;
            result_next.min_voltage    = min_reg;
            result_next.min_index      = min_idx_reg;
            result_next.frame_rejected = frame_err_reg;
            result_next.cell_count     = count_reg;
        end
        else if (emit)
        begin
            strobe_next              = 1'b1;
            result_next.cell_index   = count_reg;
            result_next.cell_voltage = cur_v;
        end
        else
        begin
            strobe_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result       = result_reg;
    assign result_valid = strobe_reg;

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import cvfs_pkg::*;

    localparam int MONITOR_CHIPS  = 5;
    localparam int POSITIONS      = MONITOR_CHIPS * CHANNELS_PER_CHIP;
    localparam int WALK_CYCLES    = POSITIONS + 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 310;
    localparam int REPORT_LIMIT   = 10;

    localparam logic [MASK_W-1:0] MASK_ALL  = {MASK_W{1'b1}};
    localparam logic [MASK_W-1:0] MASK_NONE = '0;

    // Tracks the good-value store and mask, and queues the cell and summary
    // reports that each closing request must produce.
    class cell_stats_tracker;
        logic [MASK_W-1:0] cell_mask;
        int                fill_count;
        logic [VOLT_W-1:0] frame_values [MAX_CELLS];
        logic [VOLT_W-1:0] good_values  [MAX_CELLS];
        bit                pec_seen;
        result_t           expected_reports [$];
        int                failures;

        function new();
            cell_mask = MASK_ALL;
            fill_count = 0;
            pec_seen = 1'b0;
            failures = 0;
            foreach (good_values[p])
            begin
                good_values[p] = '0;
                frame_values[p] = '0;
            end
        endfunction

        function void set_mask(logic [MASK_W-1:0] value);
            cell_mask = value;
        endfunction

        function int outstanding();
            return expected_reports.size();
        endfunction

        function void note_reading(reading_t rd);
            logic [VOLT_W-1:0]  v;
            logic [VOLT_W-1:0]  hi_v;
            logic [VOLT_W-1:0]  lo_v;
            logic [IDX_W-1:0]   hi_i;
            logic [IDX_W-1:0]   lo_i;
            logic [TOTAL_W-1:0] sum;
            int                 cells;
            result_t            rep;

            if (fill_count < POSITIONS)
            begin
                frame_values[fill_count] = rd.raw_voltage;
                if (rd.group_pec_error)
                    pec_seen = 1'b1;
                fill_count++;
            end
            if (!rd.last_reading)
                return;

            if (!pec_seen)
            begin
                for (int p = 0; p < fill_count; p++)
                    if (frame_values[p] != INVALID_READING)
                        good_values[p] = frame_values[p];
            end

            hi_v = '0;
            lo_v = '0;
            hi_i = '0;
            lo_i = '0;
            sum = '0;
            cells = 0;
            for (int p = 0; p < POSITIONS; p++)
            begin
                if (cell_mask[p])
                begin
                    v = good_values[p];
                    if (cells == 0)
                    begin
                        hi_v = v;
                        lo_v = v;
                    end
                    else
                    begin
                        // Only a strictly larger or smaller value moves an extreme.
                        if (v > hi_v)
                        begin
                            hi_v = v;
                            hi_i = IDX_W'(cells);
                        end
                        if (v < lo_v)
                        begin
                            lo_v = v;
                            lo_i = IDX_W'(cells);
                        end
                    end
                    sum = sum + TOTAL_W'(v);
                    rep = '0;
                    rep.cell_index = IDX_W'(cells);
                    rep.cell_voltage = v;
                    expected_reports.push_back(rep);
                    cells++;
                end
            end

            rep = '0;
            rep.summary_valid = 1'b1;
            rep.total_voltage = sum;
            rep.max_voltage = hi_v;
            rep.max_index = hi_i;
            rep.min_voltage = lo_v;
            rep.min_index = lo_i;
            rep.frame_rejected = pec_seen;
            rep.cell_count = IDX_W'(cells);
            expected_reports.push_back(rep);

            fill_count = 0;
            pec_seen = 1'b0;
        endfunction

        function void check_report(result_t got);
            result_t exp;
            string   bad;

            if (expected_reports.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected report: got %h", got);
                return;
            end
            exp = expected_reports.pop_front();
            bad = "";
            if (got.cell_index !== exp.cell_index)         bad = {bad, " cell_index"};
            if (got.cell_voltage !== exp.cell_voltage)     bad = {bad, " cell_voltage"};
            if (got.summary_valid !== exp.summary_valid)   bad = {bad, " summary_valid"};
            if (got.total_voltage !== exp.total_voltage)   bad = {bad, " total_voltage"};
            if (got.max_voltage !== exp.max_voltage)       bad = {bad, " max_voltage"};
            if (got.max_index !== exp.max_index)           bad = {bad, " max_index"};
            if (got.min_voltage !== exp.min_voltage)       bad = {bad, " min_voltage"};
            if (got.min_index !== exp.min_index)           bad = {bad, " min_index"};
            if (got.frame_rejected !== exp.frame_rejected) bad = {bad, " frame_rejected"};
            if (got.cell_count !== exp.cell_count)         bad = {bad, " cell_count"};
            if (bad != "")
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("report mismatch in%s: expected %h got %h", bad, exp, got);
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    reading_t          reading = '0;
    logic              mask_we = 1'b0;
    logic [MASK_W-1:0] mask_wdata = '0;
    result_t           result;
    logic              result_valid;

    cell_stats_tracker tracker;
    bit                no_idle = 1'b0;
    int                readings_sent = 0;
    int                quiet_cycles = 0;

    cell_voltage_frame_stats #(
        .MONITOR_CHIPS(MONITOR_CHIPS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .reading      (reading),
        .mask_we      (mask_we),
        .mask_wdata   (mask_wdata),
        .result       (result),
        .result_valid (result_valid)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            tracker.check_report(result);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic reading_t make_reading(logic [VOLT_W-1:0] raw, bit pec, bit last);
        reading_t rd;
        rd.raw_voltage = raw;
        rd.group_pec_error = pec;
        rd.last_reading = last;
        return rd;
    endfunction

    function automatic logic [VOLT_W-1:0] pick_voltage();
        case ($urandom_range(0, 9))
            0: return INVALID_READING;
            1: return '0;
            2: return 16'hfffe;
            // A narrow band makes ties between cells likely.
            3, 4: return VOLT_W'(3300 + $urandom_range(0, 2));
            default: return VOLT_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Called at a rising edge; returns at the edge that accepts the request.
    task automatic drive_reading(input reading_t rd);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        reading <= rd;
        do
            @(posedge clk);
        while (busy);
        tracker.note_reading(rd);
        readings_sent++;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (WALK_CYCLES) @(posedge clk);
    endtask

    task automatic write_mask(input logic [MASK_W-1:0] value);
        wait_idle();
        mask_we <= 1'b1;
        mask_wdata <= value;
        @(posedge clk);
        mask_we <= 1'b0;
        tracker.set_mask(value);
    endtask

    task automatic send_frame(input int length, input int pec_at);
        for (int i = 0; i < length; i++)
            drive_reading(make_reading(pick_voltage(), i == pec_at, i == length - 1));
    endtask

    initial
    begin
        int                length;
        int                pec_at;
        logic [MASK_W-1:0] m;

        tracker = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: single-reading frames, invalid readings, a rejected frame,
        // empty and single-cell masks, and a frame of equal readings.
        write_mask(MASK_ALL);
        drive_reading(make_reading(16'hfffe, 1'b0, 1'b1));
        drive_reading(make_reading(INVALID_READING, 1'b0, 1'b0));
        drive_reading(make_reading(16'h0001, 1'b0, 1'b0));
        drive_reading(make_reading(16'h8000, 1'b0, 1'b1));
        drive_reading(make_reading(16'h1234, 1'b0, 1'b0));
        drive_reading(make_reading(16'h4321, 1'b1, 1'b1));
        write_mask(MASK_NONE);
        drive_reading(make_reading(16'h5555, 1'b0, 1'b1));
        write_mask(MASK_W'(1) << (MASK_W - 1));
        drive_reading(make_reading(16'haaaa, 1'b0, 1'b0));
        drive_reading(make_reading(INVALID_READING, 1'b0, 1'b1));
        write_mask({(MASK_W/2){2'b01}});
        for (int i = 0; i < 4; i++)
            drive_reading(make_reading(16'h0100, 1'b0, i == 3));
        write_mask(MASK_W'(1));
        drive_reading(make_reading(16'h0000, 1'b0, 1'b1));
        write_mask(MASK_ALL);

        readings_sent = 0;
        while (readings_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 5))
                    0: m = MASK_NONE;
                    1: m = MASK_ALL;
                    2: m = MASK_W'(1);
                    3: m = MASK_W'(1) << (MASK_W - 1);
                    4:
                    begin
                        m = MASK_NONE;
                        repeat ($urandom_range(1, 5)) m[$urandom_range(0, MASK_W - 1)] = 1'b1;
                    end
                    default: m = MASK_W'({$urandom, $urandom});
                endcase
                write_mask(m);
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: length = POSITIONS;
                4: length = $urandom_range(POSITIONS + 1, POSITIONS + 4);
                default: length = $urandom_range(1, POSITIONS - 1);
            endcase
            // Some rejected frames put their error past the stored positions,
            // where it must be ignored.
            pec_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, length - 1) : -1;
            no_idle = ($urandom_range(0, 3) == 0);
            send_frame(length, pec_at);
        end
        no_idle = 1'b0;

        wait_idle();
        if (tracker.failures == 0 && tracker.outstanding() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
